// File: design/bcpd_pkg.sv
// Shared types and constants of the Bernoulli change-point detector.
`timescale 1ns / 1ps

package bcpd_pkg;

	localparam int CNT_W = 11;
	localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;
	localparam logic [CNT_W-1:0] COUNT_ONE = 11'd1;

	localparam logic REG_TRACKED_ARM = 1'b0;
	localparam logic REG_GAMMA_WEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AM_RD,
		ST_AM_CHK,
		ST_SC_RD,
		ST_SC_WAIT,
		ST_SC_RUN,
		ST_APPEND,
		ST_NM_RD,
		ST_NM_WAIT,
		ST_NM_RUN,
		ST_FINISH
	} seq_state_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_MUL,
		SC_MUL2,
		SC_DIV
	} scale_state_t;

	typedef enum logic {
		NM_IDLE,
		NM_DIV
	} norm_state_t;

endpackage

// File: design/bcpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bcpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/bcpd_scale.sv
// Iterative scaling of one weight by (1 - gamma) times its Laplace likelihood.
`timescale 1ns / 1ps

module bcpd_scale #(
	parameter int WEIGHT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [WEIGHT_BITS-1:0]            weight,
	input  logic [32:0]                       factor,
	input  logic [bcpd_pkg::CNT_W-1:0]        num,
	input  logic [bcpd_pkg::CNT_W:0]          den,
	output logic                              done,
	output logic [WEIGHT_BITS-1:0]            result
);

	localparam int W = WEIGHT_BITS;
	localparam int C = bcpd_pkg::CNT_W;
	localparam int PW = W + 34;
	localparam int DW = W + C;
	localparam int KW = $clog2(W + 34);

	bcpd_pkg::scale_state_t state_q;
	logic [KW-1:0]   cnt_q;
	logic [PW-1:0]   p_q;
	logic [W-1:0]    w_q;
	logic [C-1:0]    num_q;
	logic [C:0]      den_q;
	logic [DW-1:0]   d_q;
	logic [C+1:0]    rem_q;
	logic            done_q;

	logic [W:0]      upper;
	logic [PW-1:0]   p_next;
	logic [C+1:0]    rem_sh;
	logic            qbit;
	logic [C+1:0]    rem_next;

	always_comb begin
		upper = p_q[PW-1:33] + {1'b0, w_q};
		p_next = p_q[0] ? ({upper, p_q[32:0]} >> 1) : (p_q >> 1);
		rem_sh = {rem_q[C:0], d_q[DW-1]};
		qbit = (rem_sh >= {1'b0, den_q});
		rem_next = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcpd_pkg::SC_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				bcpd_pkg::SC_IDLE: begin
					if (start) begin
						state_q <= bcpd_pkg::SC_MUL;
						cnt_q <= '0;
					end
				end
				bcpd_pkg::SC_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == KW'(32)) begin
						state_q <= bcpd_pkg::SC_MUL2;
					end
				end
				bcpd_pkg::SC_MUL2: begin
					state_q <= bcpd_pkg::SC_DIV;
					cnt_q <= '0;
				end
				bcpd_pkg::SC_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == KW'(DW - 1)) begin
						state_q <= bcpd_pkg::SC_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= bcpd_pkg::SC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bcpd_pkg::SC_IDLE: begin
				if (start) begin
					p_q <= {{(W + 1){1'b0}}, factor};
					w_q <= weight;
					num_q <= num;
					den_q <= den;
				end
			end
			bcpd_pkg::SC_MUL: p_q <= p_next;
			bcpd_pkg::SC_MUL2: begin
				// The product now holds weight * factor; keep its Q0.32 floor.
				d_q <= DW'(p_q[W+31:32]) * DW'(num_q);
				rem_q <= '0;
			end
			bcpd_pkg::SC_DIV: begin
				d_q <= {d_q[DW-2:0], qbit};
				rem_q <= rem_next;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = (den_q == '0) ? '0 : d_q[W-1:0];

endmodule

// File: design/bcpd_norm.sv
// Iterative normalization divider: floor(w * 2^W / s), saturated at one.
`timescale 1ns / 1ps

module bcpd_norm #(
	parameter int WEIGHT_BITS = 32,
	parameter int SUM_BITS = 43
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [WEIGHT_BITS-1:0] weight,
	input  logic [SUM_BITS-1:0]    sum,
	output logic                   done,
	output logic [WEIGHT_BITS-1:0] result
);

	localparam int W = WEIGHT_BITS;
	localparam int S = SUM_BITS;
	localparam int KW = $clog2(W + 1);

	bcpd_pkg::norm_state_t state_q;
	logic [KW-1:0] cnt_q;
	logic [S:0]    r_q;
	logic [S-1:0]  s_q;
	logic [W-1:0]  q_q;
	logic          done_q;

	logic [S:0]    r_sh;
	logic          qbit;
	logic          sat;

	always_comb begin
		r_sh = {r_q[S-1:0], 1'b0};
		qbit = (r_sh >= {1'b0, s_q});
		sat = ({{(S - W){1'b0}}, weight} >= sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcpd_pkg::NM_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				bcpd_pkg::NM_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						if (sat) begin
							done_q <= 1'b1;
						end else begin
							state_q <= bcpd_pkg::NM_DIV;
						end
					end
				end
				bcpd_pkg::NM_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == KW'(W - 1)) begin
						state_q <= bcpd_pkg::NM_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= bcpd_pkg::NM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bcpd_pkg::NM_IDLE: begin
				if (start) begin
					r_q <= {{(S - W + 1){1'b0}}, weight};
					s_q <= sum;
					q_q <= sat ? '1 : '0;
				end
			end
			bcpd_pkg::NM_DIV: begin
				r_q <= qbit ? (r_sh - {1'b0, s_q}) : r_sh;
				q_q <= {q_q[W-2:0], qbit};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = q_q;

endmodule

// File: design/bernoulli_change_point_detector_top.sv
// Top level of the Bernoulli change-point detector: sequencer, expert table, registers.
`timescale 1ns / 1ps

// One observation is taken at a time and yields one result. Each item runs a maximum
// search over the n experts in the table, a scaling pass (a 33-step shift-add multiply
// and a WEIGHT_BITS+11 step divide per expert) and a renormalization pass over at most
// n+1 experts, each pass reading one entry of the single expert memory per step. A new
// item is taken while the last result still waits on the output. After a restart the
// table starts over with one expert.
module bernoulli_change_point_detector_top #(
	parameter int MAX_EXPERTS = 1024,
	parameter int WEIGHT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] time_step,
	input  logic [7:0]  observed_arm,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        restarted,
	output logic [31:0] change_point_estimate,
	output logic        reward_bit,
	output logic        overflow,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int W = WEIGHT_BITS;
	localparam int C = bcpd_pkg::CNT_W;
	localparam int IW = $clog2(MAX_EXPERTS);
	localparam int NW = $clog2(MAX_EXPERTS + 1);
	localparam int SW = W + IW + 1;
	localparam int DW = 2 * C + W;

	// Configuration registers.
	logic [7:0]  tracked_arm_q;
	logic [31:0] gamma_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == bcpd_pkg::REG_GAMMA_WEIGHT) ? gamma_q : {24'd0, tracked_arm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_arm_q <= 8'd0;
			gamma_q <= 32'd4194304;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == bcpd_pkg::REG_TRACKED_ARM) begin
				tracked_arm_q <= pwdata[7:0];
			end else begin
				gamma_q <= pwdata;
			end
		end
	end

	logic [32:0] factor;
	logic [79:0] gamma_ext;
	logic [W-1:0] gamma_w;
	assign factor = (33'd1 << 32) - {1'b0, gamma_q};
	assign gamma_ext = {gamma_q, 48'd0} >> (80 - W);
	assign gamma_w = gamma_ext[W-1:0];

	bcpd_pkg::seq_state_t state_q, state_d;
	logic [IW-1:0] idx_q;
	logic [NW-1:0] n_q;
	logic          fresh_q;
	logic [W-1:0]  best_w_q;
	logic          best_nz_q;
	logic [SW-1:0] sum_q;
	logic [31:0]   t_q;
	logic          reward_q;
	logic [31:0]   rt_q;
	logic          rst_flag_q;
	logic          ovf_q;
	logic [C-1:0]  a_q, b_q;

	logic          out_valid_q;
	logic          restarted_q;
	logic [31:0]   cpe_q;
	logic          reward_out_q;
	logic          ovf_out_q;

	// Expert memory.
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;

	bcpd_ram #(.WIDTH(DW), .DEPTH(MAX_EXPERTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Entry 0 reads as a single fresh expert after reset or restart until rewritten.
	logic          fresh_hit;
	logic [C-1:0]  v_a, v_b;
	logic [W-1:0]  v_w;
	assign fresh_hit = fresh_q && (idx_q == '0);
	assign v_a = fresh_hit ? bcpd_pkg::COUNT_ONE : ram_rdata[DW-1:DW-C];
	assign v_b = fresh_hit ? bcpd_pkg::COUNT_ONE : ram_rdata[DW-C-1:W];
	assign v_w = fresh_hit ? '1 : ram_rdata[W-1:0];

	logic          last_idx;
	assign last_idx = ((NW'(idx_q) + 1'b1) == n_q);

	logic          sc_start, sc_done;
	logic [W-1:0]  sc_result;
	logic [C:0]    sc_den;
	logic [C-1:0]  sc_num;
	assign sc_den = {1'b0, v_a} + {1'b0, v_b};
	assign sc_num = reward_q ? v_a : v_b;

	bcpd_scale #(.WEIGHT_BITS(W)) u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.weight (v_w),
		.factor (factor),
		.num    (sc_num),
		.den    (sc_den),
		.done   (sc_done),
		.result (sc_result)
	);

	logic          nm_start, nm_done;
	logic [W-1:0]  nm_result;

	bcpd_norm #(.WEIGHT_BITS(W), .SUM_BITS(SW)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nm_start),
		.weight (v_w),
		.sum    (sum_q),
		.done   (nm_done),
		.result (nm_result)
	);

	logic          nz_next;
	logic          table_full;
	logic [C-1:0]  a_inc, b_inc;
	assign nz_next = best_nz_q || ((idx_q != '0) && (v_w > best_w_q));
	assign table_full = (n_q == NW'(MAX_EXPERTS));
	assign a_inc = (reward_q && (a_q < bcpd_pkg::COUNT_MAX)) ? a_q + 1'b1 : a_q;
	assign b_inc = (!reward_q && (b_q < bcpd_pkg::COUNT_MAX)) ? b_q + 1'b1 : b_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bcpd_pkg::ST_IDLE:    if (in_valid) state_d = bcpd_pkg::ST_AM_RD;
			bcpd_pkg::ST_AM_RD:   state_d = bcpd_pkg::ST_AM_CHK;
			bcpd_pkg::ST_AM_CHK:  state_d = last_idx ? bcpd_pkg::ST_SC_RD : bcpd_pkg::ST_AM_RD;
			bcpd_pkg::ST_SC_RD:   state_d = bcpd_pkg::ST_SC_WAIT;
			bcpd_pkg::ST_SC_WAIT: state_d = bcpd_pkg::ST_SC_RUN;
			bcpd_pkg::ST_SC_RUN: begin
				if (sc_done) begin
					state_d = last_idx ? bcpd_pkg::ST_APPEND : bcpd_pkg::ST_SC_RD;
				end
			end
			bcpd_pkg::ST_APPEND: begin
				state_d = (sum_q == '0 && table_full) ? bcpd_pkg::ST_FINISH :
					(((sum_q + SW'(gamma_w)) == '0) ? bcpd_pkg::ST_FINISH : bcpd_pkg::ST_NM_RD);
				if (table_full && sum_q == '0) begin
					state_d = bcpd_pkg::ST_FINISH;
				end else if (table_full) begin
					state_d = bcpd_pkg::ST_NM_RD;
				end
			end
			bcpd_pkg::ST_NM_RD:   state_d = bcpd_pkg::ST_NM_WAIT;
			bcpd_pkg::ST_NM_WAIT: state_d = bcpd_pkg::ST_NM_RUN;
			bcpd_pkg::ST_NM_RUN: begin
				if (nm_done) begin
					state_d = last_idx ? bcpd_pkg::ST_FINISH : bcpd_pkg::ST_NM_RD;
				end
			end
			bcpd_pkg::ST_FINISH:  if (!out_valid_q || !out_stall) state_d = bcpd_pkg::ST_IDLE;
			default:              state_d = bcpd_pkg::ST_IDLE;
		endcase
	end

	// Memory and unit controls.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {a_inc, b_inc, sc_result};
		ram_raddr = idx_q;
		sc_start = 1'b0;
		nm_start = 1'b0;
		in_stall = (state_q != bcpd_pkg::ST_IDLE);
		unique case (state_q)
			bcpd_pkg::ST_SC_WAIT: sc_start = 1'b1;
			bcpd_pkg::ST_SC_RUN:  ram_we = sc_done;
			bcpd_pkg::ST_APPEND: begin
				ram_we = !table_full;
				ram_waddr = n_q[IW-1:0];
				ram_wdata = {bcpd_pkg::COUNT_ONE, bcpd_pkg::COUNT_ONE, gamma_w};
			end
			bcpd_pkg::ST_NM_WAIT: nm_start = 1'b1;
			bcpd_pkg::ST_NM_RUN: begin
				ram_we = nm_done;
				ram_wdata = {a_q, b_q, nm_result};
			end
			default: ;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcpd_pkg::ST_IDLE;
			idx_q <= '0;
			n_q <= NW'(1);
			fresh_q <= 1'b1;
			rt_q <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// In the finish state the output register is reloaded below instead.
			if (out_valid_q && !out_stall && state_q != bcpd_pkg::ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				bcpd_pkg::ST_IDLE: begin
					idx_q <= '0;
					if (in_valid) begin
						t_q <= time_step;
						reward_q <= (observed_arm == tracked_arm_q);
						rst_flag_q <= 1'b0;
						best_nz_q <= 1'b0;
						sum_q <= '0;
					end
				end
				bcpd_pkg::ST_AM_CHK: begin
					if (idx_q == '0 || v_w > best_w_q) begin
						best_w_q <= v_w;
					end
					best_nz_q <= nz_next;
					if (last_idx) begin
						idx_q <= '0;
						if (nz_next) begin
							n_q <= NW'(1);
							fresh_q <= 1'b1;
							rt_q <= t_q + 32'd1;
							rst_flag_q <= 1'b1;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				bcpd_pkg::ST_SC_WAIT: begin
					a_q <= v_a;
					b_q <= v_b;
				end
				bcpd_pkg::ST_SC_RUN: begin
					if (sc_done) begin
						sum_q <= sum_q + SW'(sc_result);
						if (idx_q == '0) begin
							fresh_q <= 1'b0;
						end
						idx_q <= last_idx ? '0 : idx_q + 1'b1;
					end
				end
				bcpd_pkg::ST_APPEND: begin
					ovf_q <= table_full;
					if (!table_full) begin
						sum_q <= sum_q + SW'(gamma_w);
						n_q <= n_q + 1'b1;
					end
				end
				bcpd_pkg::ST_NM_WAIT: begin
					a_q <= v_a;
					b_q <= v_b;
				end
				bcpd_pkg::ST_NM_RUN: begin
					if (nm_done) begin
						idx_q <= last_idx ? '0 : idx_q + 1'b1;
					end
				end
				bcpd_pkg::ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						restarted_q <= rst_flag_q;
						cpe_q <= rt_q + 32'd1;
						reward_out_q <= reward_q;
						ovf_out_q <= ovf_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign restarted = restarted_q;
	assign change_point_estimate = cpe_q;
	assign reward_bit = reward_out_q;
	assign overflow = ovf_out_q;

endmodule
